// ===== rtl/core/dpsm_pkg.sv =====
// Shared types, codes and bit positions for the drive power state machine.
// No dependencies; imported by the core and its checker.
package dpsm_pkg;

  typedef enum logic [2:0] {
    PS_NOT_READY      = 3'd0,
    PS_DISABLED       = 3'd1,
    PS_READY          = 3'd2,
    PS_SWITCHED_ON    = 3'd3,
    PS_ENABLED        = 3'd4,
    PS_QUICK_STOP     = 3'd5,
    PS_FAULT_REACTION = 3'd6,
    PS_FAULT          = 3'd7
  } power_state_t;

  typedef enum logic {
    CMD_CONTROL = 1'b0,
    CMD_MODE    = 1'b1
  } command_t;

  // Control word bit positions
  localparam int unsigned CW_SO_BIT      = 0;
  localparam int unsigned CW_EN_VOLTAGE  = 1;
  localparam int unsigned CW_QS_BIT      = 2;
  localparam int unsigned CW_EN_OP       = 3;
  localparam int unsigned CW_FR_BIT      = 7;

  // Status word bit positions
  localparam int unsigned SW_RTSO  = 0;
  localparam int unsigned SW_SO    = 1;
  localparam int unsigned SW_OE    = 2;
  localparam int unsigned SW_FLT   = 3;
  localparam int unsigned SW_QS    = 5;
  localparam int unsigned SW_SOD   = 6;

  localparam logic [15:0] STATUS_MASK = 16'h006F;

  // Entering switch on disabled rewrites the same group but holds the quick stop bit
  localparam logic [15:0] DISABLED_MASK = 16'h004F;

  localparam logic signed [7:0] MODE_LAST_LEGAL = 8'sd10;

  // Status bits under STATUS_MASK that a transition into the given state leaves
  function automatic logic [15:0] state_status(input power_state_t st);
    logic [15:0] s;
    s = '0;
    unique case (st)
      PS_DISABLED: s[SW_SOD] = 1'b1;
      PS_READY: begin
        s[SW_RTSO] = 1'b1;
        s[SW_QS]   = 1'b1;
      end
      PS_SWITCHED_ON: begin
        s[SW_RTSO] = 1'b1;
        s[SW_SO]   = 1'b1;
        s[SW_QS]   = 1'b1;
      end
      PS_ENABLED: begin
        s[SW_RTSO] = 1'b1;
        s[SW_SO]   = 1'b1;
        s[SW_OE]   = 1'b1;
        s[SW_QS]   = 1'b1;
      end
      PS_QUICK_STOP: begin
        s[SW_RTSO] = 1'b1;
        s[SW_SO]   = 1'b1;
        s[SW_OE]   = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/drive_power_state_machine.sv =====
// Drive power state machine: request register, decode/update logic, result register.
// A request is accepted into the request register and loads the result register as it moves on,
// raising out_valid; throughput one request per cycle when out_ready does not stall.
// Back-pressure from out_ready stalls both stages; a new request is taken when the request
// register is empty or moves on in the same cycle.
// Synchronous active-low reset: state "not ready", status word, mode display and mode flag zero.
module drive_power_state_machine
  import dpsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [15:0]        in_control_value,
  input  logic signed [7:0]  in_mode_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_status_bits,
  output logic signed [7:0]  out_mode_shown,
  output logic [2:0]         out_power_state,
  output logic               out_mode_accepted
);

  // Request stage
  logic              s1_valid_r;
  command_t          s1_command_r;
  logic [15:0]       s1_control_r;
  logic signed [7:0] s1_mode_r;

  // Architectural state
  power_state_t      state_r, state_nxt;
  logic [15:0]       status_r, status_nxt;
  logic signed [7:0] mode_echo_r, mode_echo_nxt;
  logic              mode_ok_r, mode_ok_nxt;

  // Result register
  logic              out_valid_r;
  logic [15:0]       out_status_r;
  logic signed [7:0] out_mode_r;
  power_state_t      out_state_r;
  logic              out_mode_ok_r;

  logic s1_go;

  // Move the request stage on when the result register is free or being drained.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the request payload until it moves on.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command_r <= command_t'(in_command);
      s1_control_r <= in_control_value;
      s1_mode_r    <= in_mode_value;
    end
  end

  // Decode the control word and apply the per-state transition rules.
  logic         so, ev, qs, eo, fr;
  logic         c_shutdown, c_disable, c_switch_on, c_enable, c_quick;
  logic         take;
  power_state_t target;

  always_comb begin
    so = s1_control_r[CW_SO_BIT];
    ev = s1_control_r[CW_EN_VOLTAGE];
    qs = s1_control_r[CW_QS_BIT];
    eo = s1_control_r[CW_EN_OP];
    fr = s1_control_r[CW_FR_BIT];

    c_shutdown  = !fr && qs && ev && !so;
    c_disable   = !fr && !ev;
    c_switch_on = !fr && !eo && qs && ev && so;
    c_enable    = !fr && eo && qs && ev && so;
    c_quick     = !fr && !qs && ev;

    take   = 1'b0;
    target = state_r;
    unique case (state_r)
      PS_NOT_READY: begin
        take   = 1'b1;
        target = PS_DISABLED;
      end
      PS_DISABLED: begin
        if (c_shutdown) begin
          take   = 1'b1;
          target = PS_READY;
        end
      end
      PS_READY: begin
        if (c_disable) begin
          take   = 1'b1;
          target = PS_DISABLED;
        end else if (c_switch_on) begin
          take   = 1'b1;
          target = PS_SWITCHED_ON;
        end else if (fr) begin
          // Fault reset re-enters ready and rewrites its status bits.
          take   = 1'b1;
          target = PS_READY;
        end
      end
      PS_SWITCHED_ON: begin
        if (c_disable) begin
          take   = 1'b1;
          target = PS_DISABLED;
        end else if (c_shutdown) begin
          take   = 1'b1;
          target = PS_READY;
        end else if (c_enable) begin
          take   = 1'b1;
          target = PS_ENABLED;
        end
      end
      PS_ENABLED: begin
        if (c_disable) begin
          take   = 1'b1;
          target = PS_DISABLED;
        end else if (c_shutdown) begin
          take   = 1'b1;
          target = PS_READY;
        end else if (c_switch_on) begin
          take   = 1'b1;
          target = PS_SWITCHED_ON;
        end else if (c_quick) begin
          take   = 1'b1;
          target = PS_QUICK_STOP;
        end
      end
      PS_QUICK_STOP: begin
        if (c_enable) begin
          take   = 1'b1;
          target = PS_ENABLED;
        end else if (c_disable) begin
          take   = 1'b1;
          target = PS_DISABLED;
        end
      end
      // Fault states are never entered; if held, ignore every control word.
      PS_FAULT_REACTION, PS_FAULT: begin
        take   = 1'b0;
        target = state_r;
      end
    endcase
  end

  // Next architectural state for the request in stage 1.
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    mode_echo_nxt = mode_echo_r;
    mode_ok_nxt   = mode_ok_r;
    unique case (s1_command_r)
      CMD_CONTROL: begin
        if (take) begin
          state_nxt  = target;
          // Disable voltage leaves the quick stop bit as it was.
          status_nxt = (status_r & ~((target == PS_DISABLED) ? DISABLED_MASK : STATUS_MASK))
                       | state_status(target);
        end
      end
      CMD_MODE: begin
        // Echo every byte; flag only modes 0 through the last legal one.
        mode_echo_nxt = s1_mode_r;
        mode_ok_nxt   = (s1_mode_r >= 8'sd0) && (s1_mode_r <= MODE_LAST_LEGAL);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PS_NOT_READY;
      status_r    <= '0;
      mode_echo_r <= '0;
      mode_ok_r   <= 1'b0;
    end else if (s1_go) begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      mode_echo_r <= mode_echo_nxt;
      mode_ok_r   <= mode_ok_nxt;
    end
  end

  // Result register: load on advance, drop valid once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r  <= status_nxt;
      out_mode_r    <= mode_echo_nxt;
      out_state_r   <= state_nxt;
      out_mode_ok_r <= mode_ok_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_bits   = out_status_r;
  assign out_mode_shown    = out_mode_r;
  assign out_power_state   = out_state_r;
  assign out_mode_accepted = out_mode_ok_r;

endmodule

// ===== rtl/core/dpsm_checker.sv =====
// Port-level checks for drive_power_state_machine, attached by bind.
// Depends on dpsm_pkg.
module dpsm_checker
  import dpsm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [15:0]       out_status_bits,
  input logic signed [7:0] out_mode_shown,
  input logic [2:0]        out_power_state,
  input logic              out_mode_accepted
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status_bits)
      && $stable(out_mode_shown) && $stable(out_power_state)
      && $stable(out_mode_accepted))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Fault states are never reported and the fault bit never rises.
  a_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_power_state != PS_FAULT && out_power_state != PS_FAULT_REACTION
      && !out_status_bits[SW_FLT])
    else $error("fault state or fault bit reported");

  // Operation enabled state always shows operation enabled and quick stop bits.
  a_enabled_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_power_state == PS_ENABLED |->
      out_status_bits[SW_OE] && out_status_bits[SW_QS] && !out_status_bits[SW_SOD])
    else $error("status word disagrees with enabled state");

  // Only the state group of status bits ever rises.
  a_status_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_bits & ~STATUS_MASK) == 16'h0000)
    else $error("status bit outside the state group set");

endmodule

bind drive_power_state_machine dpsm_checker u_dpsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status_bits   (out_status_bits),
  .out_mode_shown    (out_mode_shown),
  .out_power_state   (out_power_state),
  .out_mode_accepted (out_mode_accepted)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the drive power state machine: directed and random requests.
// Holds its own model of the state, status word and mode display; depends on dpsm_pkg and the RTL.
import dpsm_pkg::*;

typedef struct {
  logic [15:0]       status;
  logic signed [7:0] mode;
  logic [2:0]        state;
  logic              accepted;
} drive_result_t;

class drive_status_scoreboard;
  power_state_t      drive_state;
  logic [15:0]       stat_image;
  logic signed [7:0] shown_mode;
  logic              mode_ok;
  drive_result_t     expected_results[$];
  int                errors;

  function new();
    drive_state = PS_NOT_READY;
    stat_image  = '0;
    shown_mode  = '0;
    mode_ok     = 1'b0;
    errors      = 0;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Force the state bits of the status word; leave the rest alone
  function void enter_state(power_state_t st);
    drive_state = st;
    stat_image[SW_RTSO] = (st != PS_DISABLED);
    stat_image[SW_SO]   = (st == PS_SWITCHED_ON || st == PS_ENABLED || st == PS_QUICK_STOP);
    stat_image[SW_OE]   = (st == PS_ENABLED || st == PS_QUICK_STOP);
    stat_image[SW_FLT]  = 1'b0;
    // Disable voltage holds the quick stop bit
    if (st != PS_DISABLED)
      stat_image[SW_QS] = (st == PS_READY || st == PS_SWITCHED_ON || st == PS_ENABLED);
    stat_image[SW_SOD]  = (st == PS_DISABLED);
  endfunction

  function void apply_control_word(logic [15:0] cw);
    logic so, ev, qs, eo, fr;
    logic shutdown, disable_v, switch_on, enable_op, quick;
    so = cw[CW_SO_BIT];
    ev = cw[CW_EN_VOLTAGE];
    qs = cw[CW_QS_BIT];
    eo = cw[CW_EN_OP];
    fr = cw[CW_FR_BIT];
    shutdown  = !fr && qs && ev && !so;
    disable_v = !fr && !ev;
    switch_on = !fr && !eo && qs && ev && so;
    enable_op = !fr && eo && qs && ev && so;
    quick     = !fr && !qs && ev;
    case (drive_state)
      PS_NOT_READY: enter_state(PS_DISABLED);
      PS_DISABLED: if (shutdown) enter_state(PS_READY);
      PS_READY: begin
        if (disable_v) enter_state(PS_DISABLED);
        else if (switch_on) enter_state(PS_SWITCHED_ON);
        else if (fr) enter_state(PS_READY);
      end
      PS_SWITCHED_ON: begin
        if (disable_v) enter_state(PS_DISABLED);
        else if (shutdown) enter_state(PS_READY);
        else if (enable_op) enter_state(PS_ENABLED);
      end
      PS_ENABLED: begin
        if (disable_v) enter_state(PS_DISABLED);
        else if (shutdown) enter_state(PS_READY);
        else if (switch_on) enter_state(PS_SWITCHED_ON);
        else if (quick) enter_state(PS_QUICK_STOP);
      end
      PS_QUICK_STOP: begin
        if (enable_op) enter_state(PS_ENABLED);
        else if (disable_v) enter_state(PS_DISABLED);
      end
      default: ;
    endcase
  endfunction

  function void apply_mode_byte(logic signed [7:0] mv);
    if (mv >= 0 && mv <= MODE_LAST_LEGAL) begin
      mode_ok = 1'b1;
    end else begin
      mode_ok = 1'b0;
    end
    shown_mode = mv;
  endfunction

  function void note_request(command_t cmd, logic [15:0] cw, logic signed [7:0] mv);
    drive_result_t r;
    if (cmd == CMD_CONTROL) apply_control_word(cw);
    else apply_mode_byte(mv);
    r.status   = stat_image;
    r.mode     = shown_mode;
    r.state    = drive_state;
    r.accepted = mode_ok;
    expected_results = {expected_results, r};
  endfunction

  function void flag(string field, logic [15:0] exp_v, logic [15:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
  endfunction

  function void check_result(logic [15:0] status, logic signed [7:0] mode, logic [2:0] state,
                             logic accepted);
    drive_result_t r;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with no request pending, actual status %h state %0d",
               $time, status, state);
      return;
    end
    r = expected_results.pop_front();
    if (status !== r.status) flag("status_bits", r.status, status);
    if (mode !== r.mode) flag("mode_shown", 16'(r.mode), 16'(mode));
    if (state !== r.state) flag("power_state", 16'(r.state), 16'(state));
    if (accepted !== r.accepted) flag("mode_accepted", 16'(r.accepted), 16'(accepted));
  endfunction
endclass

module testbench;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // Canonical control words for the directed walk
  localparam logic [15:0] CW_WORD_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_WORD_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_WORD_ENABLE      = 16'h000F;
  localparam logic [15:0] CW_WORD_QUICK_STOP  = 16'h0002;
  localparam logic [15:0] CW_WORD_DISABLE     = 16'h0000;
  localparam logic [15:0] CW_WORD_FAULT_RESET = 16'h0080;

  typedef enum int {
    K_SHUTDOWN, K_SWITCH_ON, K_ENABLE, K_QUICK, K_DISABLE, K_FAULT_RESET, K_NOISE
  } cw_kind_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [15:0]       in_control_value;
  logic signed [7:0] in_mode_value;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       out_status_bits;
  logic signed [7:0] out_mode_shown;
  logic [2:0]        out_power_state;
  logic              out_mode_accepted;

  drive_status_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;

  drive_power_state_machine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_control_value  (in_control_value),
    .in_mode_value     (in_mode_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status_bits   (out_status_bits),
    .out_mode_shown    (out_mode_shown),
    .out_power_state   (out_power_state),
    .out_mode_accepted (out_mode_accepted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure: switch between random stall patterns.
  // Modes: always ready, coin flip, one in four, rarely ready.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor both channels on the sampled (pre-edge) values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(command_t'(in_command), in_control_value, in_mode_value);
      if (out_valid && out_ready)
        sb.check_result(out_status_bits, out_mode_shown, out_power_state, out_mode_accepted);
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(command_t cmd, logic [15:0] cw, logic signed [7:0] mv);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_control_value <= cw;
    in_mode_value    <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and hold off until every pending request has produced its result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build a control word for one command; scramble the don't-care bits
  function automatic logic [15:0] make_control_word(cw_kind_t kind);
    logic [15:0] w;
    w = 16'($urandom);
    if (kind == K_NOISE) return w;
    w[CW_FR_BIT] = 1'b0;
    case (kind)
      K_SHUTDOWN: begin
        w[CW_QS_BIT]     = 1'b1;
        w[CW_EN_VOLTAGE] = 1'b1;
        w[CW_SO_BIT]     = 1'b0;
      end
      K_SWITCH_ON: begin
        w[CW_EN_OP]      = 1'b0;
        w[CW_QS_BIT]     = 1'b1;
        w[CW_EN_VOLTAGE] = 1'b1;
        w[CW_SO_BIT]     = 1'b1;
      end
      K_ENABLE: begin
        w[CW_EN_OP]      = 1'b1;
        w[CW_QS_BIT]     = 1'b1;
        w[CW_EN_VOLTAGE] = 1'b1;
        w[CW_SO_BIT]     = 1'b1;
      end
      K_QUICK: begin
        w[CW_QS_BIT]     = 1'b0;
        w[CW_EN_VOLTAGE] = 1'b1;
      end
      K_DISABLE: w[CW_EN_VOLTAGE] = 1'b0;
      K_FAULT_RESET: w[CW_FR_BIT] = 1'b1;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned pick;
    logic signed [7:0] mv;

    sb = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_CONTROL;
    in_control_value <= '0;
    in_mode_value    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk: mode write while not ready, then a walk through transitions of the profile
    send_request(CMD_MODE, '0, 8'sd10);
    send_request(CMD_CONTROL, CW_WORD_DISABLE, '0);      // not ready -> disabled
    send_request(CMD_CONTROL, CW_WORD_ENABLE, '0);       // ignored in disabled
    send_request(CMD_CONTROL, CW_WORD_SHUTDOWN, '0);     // -> ready
    send_request(CMD_CONTROL, CW_WORD_FAULT_RESET, '0);  // re-enter ready
    send_request(CMD_CONTROL, CW_WORD_SWITCH_ON, '0);    // -> switched on
    send_request(CMD_CONTROL, CW_WORD_ENABLE, '0);       // -> enabled
    send_request(CMD_CONTROL, CW_WORD_QUICK_STOP, '0);   // -> quick stop
    send_request(CMD_CONTROL, CW_WORD_SWITCH_ON, '0);    // ignored in quick stop
    send_request(CMD_CONTROL, CW_WORD_ENABLE, '0);       // back to enabled
    send_request(CMD_CONTROL, CW_WORD_SWITCH_ON, '0);    // -> switched on
    send_request(CMD_CONTROL, CW_WORD_SHUTDOWN, '0);     // -> ready
    send_request(CMD_CONTROL, CW_WORD_DISABLE, '0);      // -> disabled
    send_request(CMD_CONTROL, 16'hFFFF, '0);             // fault reset set: ignored
    send_request(CMD_CONTROL, 16'hFF76, '0);             // shutdown with noise bits
    send_request(CMD_CONTROL, 16'hFFFF, '0);             // fault reset in ready
    send_request(CMD_CONTROL, 16'hFF77, '0);             // switch on with noise bits
    send_request(CMD_CONTROL, 16'hFF7F, '0);             // enable with noise bits
    send_request(CMD_CONTROL, 16'hFF7B, '0);             // quick stop with noise bits
    send_request(CMD_CONTROL, 16'hFF79, '0);             // disable voltage from quick stop
    // Mode extremes, legal edges and illegal bytes, which are echoed but not flagged as accepted
    send_request(CMD_MODE, '0, -8'sd128);
    send_request(CMD_MODE, '0, 8'sd127);
    send_request(CMD_MODE, '0, -8'sd1);
    send_request(CMD_MODE, '0, 8'sd0);
    send_request(CMD_MODE, '0, 8'sd11);

    // Random part: mostly well-formed commands, some raw words and mode bytes
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        mv = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(0, 255));
        send_request(CMD_MODE, 16'($urandom), mv);
      end else if (pick < 27) begin
        send_request(CMD_CONTROL, make_control_word(K_NOISE), 8'($urandom));
      end else begin
        send_request(CMD_CONTROL, make_control_word(cw_kind_t'($urandom_range(0, 5))),
                     8'($urandom));
      end
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          idle_gap($urandom_range(1, 8));
          burst_left = $urandom_range(1, 40);
        end
      end
    end

    // Wait for the tail, then allow for any stray late result
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dpsm_pkg.sv
rtl/core/drive_power_state_machine.sv
rtl/core/dpsm_checker.sv
dv/testbench.sv
